// ----- design/fpaw_pkg.sv -----
// Shared types, constants and codes for the feedforward PID angle-wrap block.
`timescale 1ns / 1ps
`default_nettype none
package fpaw_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned TERM_W    = 66;

  localparam logic [2:0] OP_EXT_FF   = 3'd0;
  localparam logic [2:0] OP_TGT_FF   = 3'd1;
  localparam logic [2:0] OP_VEL_FF   = 3'd2;
  localparam logic [2:0] OP_ANGLE    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_GAIN_FF    = 3'd3;
  localparam logic [2:0] REG_DRIVE_LOW  = 3'd4;
  localparam logic [2:0] REG_DRIVE_HIGH = 3'd5;
  localparam logic [2:0] REG_INTEG_LOW  = 3'd6;
  localparam logic [2:0] REG_INTEG_HIGH = 3'd7;

  localparam logic [34:0] DEG360 = 35'd23592960;
  localparam logic [34:0] DEG180 = 35'd11796480;
  localparam logic [3:0]  FOLD_STEPS_M1 = 4'd9;
  localparam logic [5:0]  DIV_STEPS_M1  = 6'd47;

  typedef enum logic [1:0] {G_P, G_I, G_D, G_FF} gain_sel_e;
  typedef enum logic [2:0] {B_SP, B_VEL, B_FOLD, B_ERR, B_DMEAS, B_ACC} bsel_e;
  typedef enum logic [1:0] {MD_FF, MD_P, MD_D, MD_I} mdst_e;
  typedef enum logic [1:0] {FS_VEL, FS_MEAS, FS_SP, FS_ERR} fsel_e;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      lin;
    logic      fold_start;
    fsel_e     fold_sel;
    logic      mul_lo;
    logic      mul_hi;
    gain_sel_e gsel;
    bsel_e     bsel;
    mdst_e     mdst;
    logic      hold;
    logic      iclamp;
    logic      total;
  } fpaw_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fold_busy;
    logic       div_busy;
    logic       need_div;
  } fpaw_sts_t;

endpackage
`default_nettype wire

// ----- design/fpaw_in_if.sv -----
// Input channel: operation, measurement, setpoint and external feedforward.
`timescale 1ns / 1ps
`default_nettype none
interface fpaw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] measured;
  logic [31:0] setpoint;
  logic [31:0] ff_external;
  modport source (output valid, operation, measured, setpoint, ff_external, input ready);
  modport sink   (input valid, operation, measured, setpoint, ff_external, output ready);
endinterface
`default_nettype wire

// ----- design/fpaw_out_if.sv -----
// Output channel: drive, loop error and clamp flags.
`timescale 1ns / 1ps
`default_nettype none
interface fpaw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive;
  logic [31:0] loop_error;
  logic        drive_clamped;
  logic        integ_clamped;
  modport source (output valid, drive, loop_error, drive_clamped, integ_clamped, input ready);
  modport sink   (input valid, drive, loop_error, drive_clamped, integ_clamped, output ready);
endinterface
`default_nettype wire

// ----- design/fpaw_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface fpaw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/fpaw_datapath.sv -----
// Datapath: registers, angle fold unit, shared multiplier, divider and clamps.
`timescale 1ns / 1ps
`default_nettype none
module fpaw_datapath import fpaw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fpaw_cmd_t   cmd_i,
  output fpaw_sts_t        sts_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] measured_i,
  input  wire logic [31:0] setpoint_i,
  input  wire logic [31:0] ff_external_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic [31:0]      drive_o,
  output logic [31:0]      loop_error_o,
  output logic             drive_clamped_o,
  output logic             integ_clamped_o
);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] cfg_q [NUM_REGS];
  logic [2:0]         op_q;
  logic signed [31:0] meas_q, sp_q, ffx_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] prev_meas_q, prev_sp_q;
  logic signed [31:0] fold1_q, cur_q, spw_q, err_q;
  logic signed [TERM_W-1:0] ff_q, p_q, d_q, i_q;
  logic signed [64:0] mlo_q;
  logic               icl_q;
  logic [31:0]        drive_q, lerr_q;
  logic               dcl_q, iclo_q;

  logic               fbusy_q;
  logic [3:0]         fcnt_q;
  logic [34:0]        fr_q;
  logic               fneg_q;
  fsel_e              fsel_q;

  logic               dbusy_q;
  logic [5:0]         dcnt_q;
  logic [31:0]        drem_q;
  logic [ACC_W-1:0]   dquo_q;
  logic               dneg_q;

  logic signed [31:0] kp, ki, kd, kff, dlo, dhi, ilo, ihi;
  assign kp  = cfg_q[REG_GAIN_P];
  assign ki  = cfg_q[REG_GAIN_I];
  assign kd  = cfg_q[REG_GAIN_D];
  assign kff = cfg_q[REG_GAIN_FF];
  assign dlo = cfg_q[REG_DRIVE_LOW];
  assign dhi = cfg_q[REG_DRIVE_HIGH];
  assign ilo = cfg_q[REG_INTEG_LOW];
  assign ihi = cfg_q[REG_INTEG_HIGH];

  logic ki_pos;
  assign ki_pos = !ki[31] && (ki != 32'sd0);

  // fold unit
  logic signed [33:0] fin;
  logic [34:0]        fin_mag, fshift, fr_next, fres_u;
  logic signed [31:0] fres;
  always_comb begin
    case (cmd_i.fold_sel)
      FS_VEL:  fin = 34'(sp_q) - 34'(prev_sp_q);
      FS_MEAS: fin = 34'(meas_q);
      FS_SP:   fin = 34'(sp_q);
      FS_ERR:  fin = 34'(spw_q) - 34'(cur_q);
      default: fin = '0;
    endcase
    fin_mag = fin[33] ? 35'(-fin) : 35'(fin);
    fshift  = DEG360 << fcnt_q;
    fr_next = (fr_q >= fshift) ? fr_q - fshift : fr_q;
    fres_u  = (fneg_q && fr_next != '0) ? DEG360 - fr_next : fr_next;
    if (fres_u >= DEG180) fres_u = fres_u - DEG360;
    fres = fres_u[31:0];
  end

  // shared multiplier
  logic signed [31:0]  gain;
  logic signed [48:0]  bval;
  logic signed [32:0]  mop;
  logic signed [64:0]  prod;
  logic signed [TERM_W-1:0] mres;
  logic signed [32:0]  dmeas;
  always_comb begin
    case (cmd_i.gsel)
      G_P:     gain = kp;
      G_I:     gain = ki;
      G_D:     gain = kd;
      G_FF:    gain = kff;
      default: gain = kp;
    endcase
    dmeas = -33'(sat32(34'(cur_q) - 34'(prev_meas_q)));
    case (cmd_i.bsel)
      B_SP:    bval = 49'(sp_q);
      B_VEL:   bval = 49'(sat32(34'(sp_q) - 34'(prev_sp_q)));
      B_FOLD:  bval = 49'(fold1_q);
      B_ERR:   bval = 49'(err_q);
      B_DMEAS: bval = 49'(dmeas);
      B_ACC:   bval = 49'(acc_q);
      default: bval = '0;
    endcase
    mop  = cmd_i.mul_hi ? bval[48:16] : $signed({17'b0, bval[15:0]});
    prod = 65'(gain) * 65'(mop);
    mres = TERM_W'(prod) + TERM_W'(mlo_q >>> FRAC_BITS);
  end

  // hold, integral clamp with divider step, and total
  logic signed [67:0] psum, dhi_x, dlo_x;
  logic               err_pos, err_neg, hold;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic               i_over, i_under;
  logic signed [31:0] ilim;
  logic signed [ACC_W-1:0] dvd;
  logic [ACC_W-1:0]   dvd_mag;
  logic [32:0]        drem_sh;
  logic               dbit;
  logic [ACC_W-1:0]   dquo_next;
  always_comb begin
    psum    = 68'(p_q) + 68'(i_q) + 68'(d_q) + 68'(ff_q);
    dhi_x   = 68'(dhi);
    dlo_x   = 68'(dlo);
    err_pos = !err_q[31] && (err_q != '0);
    err_neg = err_q[31];
    hold    = (psum >= dhi_x && err_pos) || (psum <= dlo_x && err_neg);
    acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(err_q);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else acc_sat = acc_sum[ACC_W-1:0];
    i_over  = i_q > TERM_W'(ihi);
    i_under = !i_over && (i_q < TERM_W'(ilo));
    ilim    = i_over ? ihi : ilo;
    dvd     = {ilim, 16'b0};
    dvd_mag = dvd[ACC_W-1] ? ACC_W'(-dvd) : ACC_W'(dvd);
    drem_sh = {drem_q, dquo_q[ACC_W-1]};
    dbit    = drem_sh >= 33'(ki);
    dquo_next = {dquo_q[ACC_W-2:0], dbit};
  end

  assign sts_o.op        = op_q;
  assign sts_o.fold_busy = fbusy_q;
  assign sts_o.div_busy  = dbusy_q;
  assign sts_o.need_div  = (i_over || i_under) && ki_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) cfg_q[k] <= '0;
      acc_q       <= '0;
      prev_meas_q <= '0;
      prev_sp_q   <= '0;
      fbusy_q     <= 1'b0;
      dbusy_q     <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.clear) begin
        acc_q       <= '0;
        prev_meas_q <= '0;
        prev_sp_q   <= '0;
      end
      if (cmd_i.fold_start) fbusy_q <= 1'b1;
      else if (fbusy_q && fcnt_q == '0) fbusy_q <= 1'b0;
      if (cmd_i.hold && !hold) acc_q <= acc_sat;
      if (cmd_i.iclamp && sts_o.need_div) dbusy_q <= 1'b1;
      else if (dbusy_q && dcnt_q == '0) begin
        dbusy_q <= 1'b0;
        acc_q   <= dneg_q ? ACC_W'(-dquo_next) : dquo_next;
      end
      if (cmd_i.total) begin
        prev_meas_q <= cur_q;
        if (op_q == OP_ANGLE) prev_sp_q <= spw_q;
        else if (op_q == OP_VEL_FF) prev_sp_q <= sp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      meas_q <= measured_i;
      sp_q   <= setpoint_i;
      ffx_q  <= ff_external_i;
    end
    if (cmd_i.fold_start) begin
      fr_q   <= fin_mag;
      fneg_q <= fin[33];
      fcnt_q <= FOLD_STEPS_M1;
      fsel_q <= cmd_i.fold_sel;
    end else if (fbusy_q) begin
      fr_q   <= fr_next;
      fcnt_q <= fcnt_q - 4'd1;
      if (fcnt_q == '0) begin
        case (fsel_q)
          FS_VEL:  fold1_q <= fres;
          FS_MEAS: cur_q   <= fres;
          FS_SP:   spw_q   <= fres;
          FS_ERR:  err_q   <= fres;
          default: err_q   <= fres;
        endcase
      end
    end
    if (cmd_i.lin) begin
      err_q <= sat32(34'(sp_q) - 34'(meas_q));
      cur_q <= meas_q;
      ff_q  <= (op_q == OP_EXT_FF) ? TERM_W'(ffx_q) : '0;
    end
    if (cmd_i.mul_lo) mlo_q <= prod;
    if (cmd_i.mul_hi) begin
      case (cmd_i.mdst)
        MD_FF:   ff_q <= mres;
        MD_P:    p_q  <= mres;
        MD_D:    d_q  <= mres;
        MD_I:    i_q  <= mres;
        default: i_q  <= mres;
      endcase
    end
    if (cmd_i.iclamp) begin
      icl_q <= i_over || i_under;
      if (i_over || i_under) i_q <= TERM_W'(ilim);
      if (sts_o.need_div) begin
        dneg_q <= dvd[ACC_W-1];
        dquo_q <= dvd_mag;
        drem_q <= '0;
        dcnt_q <= DIV_STEPS_M1;
      end
    end else if (dbusy_q) begin
      drem_q <= dbit ? 32'(drem_sh - 33'(ki)) : drem_sh[31:0];
      dquo_q <= dquo_next;
      dcnt_q <= dcnt_q - 6'd1;
    end
    if (cmd_i.total) begin
      if (psum > dhi_x) begin
        drive_q <= dhi;
        dcl_q   <= 1'b1;
      end else if (psum < dlo_x) begin
        drive_q <= dlo;
        dcl_q   <= 1'b1;
      end else begin
        drive_q <= psum[31:0];
        dcl_q   <= 1'b0;
      end
      lerr_q <= err_q;
      iclo_q <= icl_q;
    end
    if (cmd_i.clear) begin
      drive_q <= '0;
      lerr_q  <= '0;
      dcl_q   <= 1'b0;
      iclo_q  <= 1'b0;
    end
  end

  assign drive_o         = drive_q;
  assign loop_error_o    = lerr_q;
  assign drive_clamped_o = dcl_q;
  assign integ_clamped_o = iclo_q;

endmodule
`default_nettype wire

// ----- design/fpaw_ctrl.sv -----
// Controller: sequences folds, multiplies, integrator update and output handshake.
`timescale 1ns / 1ps
`default_nettype none
module fpaw_ctrl import fpaw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  input  wire fpaw_sts_t sts_i,
  output fpaw_cmd_t      cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_LIN    = 5'd2;
  localparam logic [4:0] S_FSTART = 5'd3;
  localparam logic [4:0] S_FWAIT  = 5'd4;
  localparam logic [4:0] S_FFLO   = 5'd5;
  localparam logic [4:0] S_FFHI   = 5'd6;
  localparam logic [4:0] S_PLO    = 5'd7;
  localparam logic [4:0] S_PHI    = 5'd8;
  localparam logic [4:0] S_DLO    = 5'd9;
  localparam logic [4:0] S_DHI    = 5'd10;
  localparam logic [4:0] S_I1LO   = 5'd11;
  localparam logic [4:0] S_I1HI   = 5'd12;
  localparam logic [4:0] S_HOLD   = 5'd13;
  localparam logic [4:0] S_I2LO   = 5'd14;
  localparam logic [4:0] S_I2HI   = 5'd15;
  localparam logic [4:0] S_ICLAMP = 5'd16;
  localparam logic [4:0] S_DIV    = 5'd17;
  localparam logic [4:0] S_TOTAL  = 5'd18;

  logic [4:0] state_q, state_d;
  logic [1:0] fidx_q, fidx_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    fidx_d   = fidx_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.fold_sel = fsel_e'(fidx_q);
    cmd_o.gsel = G_P;
    cmd_o.bsel = B_ERR;
    cmd_o.mdst = MD_P;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_LIN;
        end
      end
      S_LIN: begin
        fidx_d = 2'd0;
        if (sts_i.op == OP_CLEAR) state_d = S_CLR;
        else if (sts_i.op == OP_ANGLE) state_d = S_FSTART;
        else begin
          cmd_o.lin = 1'b1;
          state_d = (sts_i.op == OP_TGT_FF || sts_i.op == OP_VEL_FF) ? S_FFLO : S_PLO;
        end
      end
      S_CLR: begin
        if (out_free) begin
          cmd_o.clear = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FSTART: begin
        cmd_o.fold_start = 1'b1;
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        if (!sts_i.fold_busy) begin
          if (fidx_q == 2'd3) state_d = S_FFLO;
          else begin
            fidx_d = fidx_q + 2'd1;
            state_d = S_FSTART;
          end
        end
      end
      S_FFLO, S_FFHI: begin
        cmd_o.gsel = G_FF;
        cmd_o.mdst = MD_FF;
        if (sts_i.op == OP_ANGLE) cmd_o.bsel = B_FOLD;
        else if (sts_i.op == OP_TGT_FF) cmd_o.bsel = B_SP;
        else cmd_o.bsel = B_VEL;
        cmd_o.mul_lo = (state_q == S_FFLO);
        cmd_o.mul_hi = (state_q == S_FFHI);
        state_d = (state_q == S_FFLO) ? S_FFHI : S_PLO;
      end
      S_PLO, S_PHI: begin
        cmd_o.mul_lo = (state_q == S_PLO);
        cmd_o.mul_hi = (state_q == S_PHI);
        state_d = (state_q == S_PLO) ? S_PHI : S_DLO;
      end
      S_DLO, S_DHI: begin
        cmd_o.gsel = G_D;
        cmd_o.bsel = B_DMEAS;
        cmd_o.mdst = MD_D;
        cmd_o.mul_lo = (state_q == S_DLO);
        cmd_o.mul_hi = (state_q == S_DHI);
        state_d = (state_q == S_DLO) ? S_DHI : S_I1LO;
      end
      S_I1LO, S_I1HI, S_I2LO, S_I2HI: begin
        cmd_o.gsel = G_I;
        cmd_o.bsel = B_ACC;
        cmd_o.mdst = MD_I;
        cmd_o.mul_lo = (state_q == S_I1LO) || (state_q == S_I2LO);
        cmd_o.mul_hi = (state_q == S_I1HI) || (state_q == S_I2HI);
        case (state_q)
          S_I1LO:  state_d = S_I1HI;
          S_I1HI:  state_d = S_HOLD;
          S_I2LO:  state_d = S_I2HI;
          default: state_d = S_ICLAMP;
        endcase
      end
      S_HOLD: begin
        cmd_o.hold = 1'b1;
        state_d = S_I2LO;
      end
      S_ICLAMP: begin
        cmd_o.iclamp = 1'b1;
        state_d = sts_i.need_div ? S_DIV : S_TOTAL;
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_TOTAL;
      end
      S_TOTAL: begin
        if (out_free) begin
          cmd_o.total = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fidx_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fidx_q   <= fidx_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/feedforward_pid_angle_wrap.sv -----
// Top level of the feedforward PID controller with angle-wrap mode.
// Usage:
//   in_i   : one transaction per control step (operation, measured, setpoint,
//            ff_external). Taken when valid and ready are both high.
//   out_o  : one transaction per input (drive, loop_error, clamp flags), held
//            in an output register until taken.
//   cfg_i  : register writes (index 0..7), always ready; write only when idle.
// One shared 32x33 multiplier and one sequencer serve every operation. A
// wrapped angle runs four angle folds, and a bit-serial rescale divider
// step is added when the integral term clamps with a positive integral gain.
// One item is in work at a time; the next input is taken as soon as the
// previous result sits in the output register. When the receiver stalls, the
// finished result holds and the next item waits before its final step.
// Reset clears the registers, the accumulator and the previous values.
`timescale 1ns / 1ps
`default_nettype none
module feedforward_pid_angle_wrap import fpaw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpaw_in_if.sink   in_i,
  fpaw_out_if.source out_o,
  fpaw_cfg_if.sink  cfg_i
);

  fpaw_cmd_t cmd;
  fpaw_sts_t sts;

  assign cfg_i.ready = 1'b1;

  fpaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fpaw_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (in_i.operation),
    .measured_i      (in_i.measured),
    .setpoint_i      (in_i.setpoint),
    .ff_external_i   (in_i.ff_external),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .drive_o         (out_o.drive),
    .loop_error_o    (out_o.loop_error),
    .drive_clamped_o (out_o.drive_clamped),
    .integ_clamped_o (out_o.integ_clamped)
  );

endmodule
`default_nettype wire

// ----- test/feedforward_pid_angle_wrap_tb.sv -----
// Self-checking testbench for the feedforward PID controller with angle-wrap mode.
`timescale 1ns / 1ps
module feedforward_pid_angle_wrap_tb;
  import fpaw_pkg::*;

  typedef struct {
    logic [31:0] drive;
    logic [31:0] loop_error;
    logic        drive_clamped;
    logic        integ_clamped;
  } ctl_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] meas;
    logic [31:0] sp;
    logic [31:0] ffx;
    bit          typed;
    ctl_result_t res;
  } step_row_t;

  localparam longint ACC_HI = (longint'(1) <<< 47) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< 47);
  localparam longint FULL_TURN = 360 * 65536;
  localparam longint HALF_TURN = 180 * 65536;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpaw_in_if  in_ch ();
  fpaw_out_if out_ch ();
  fpaw_cfg_if cfg_ch ();

  feedforward_pid_angle_wrap dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  longint      gains_regs [NUM_REGS];
  longint      accum;
  longint      last_meas;
  longint      last_sp;
  ctl_result_t pending_q [$];
  step_row_t   rows [$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          mismatches = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_settings = 0;

  function automatic longint scaled_mul(longint g, longint b);
    longint hi, lo;
    hi = b >>> 16;
    lo = b - hi * 65536;
    return g * hi + ((g * lo) >>> 16);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint wrap_angle(longint v);
    longint r;
    r = v % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    if (r >= HALF_TURN) r -= FULL_TURN;
    return r;
  endfunction

  function automatic ctl_result_t control_step(logic [2:0] op, logic [31:0] m_raw,
                                               logic [31:0] s_raw, logic [31:0] f_raw);
    ctl_result_t r;
    longint meas, sp, err, ff, cur, p, d, pre, iout, total, spw;
    longint kp, ki, kd, kff, dlo, dhi, ilo, ihi;
    bit hold, dcl, icl;
    meas = longint'($signed(m_raw));
    sp = longint'($signed(s_raw));
    kp = gains_regs[REG_GAIN_P];
    ki = gains_regs[REG_GAIN_I];
    kd = gains_regs[REG_GAIN_D];
    kff = gains_regs[REG_GAIN_FF];
    dlo = gains_regs[REG_DRIVE_LOW];
    dhi = gains_regs[REG_DRIVE_HIGH];
    ilo = gains_regs[REG_INTEG_LOW];
    ihi = gains_regs[REG_INTEG_HIGH];
    ff = 0;
    cur = meas;
    hold = 0;
    dcl = 0;
    icl = 0;
    if (op == OP_CLEAR) begin
      accum = 0;
      last_meas = 0;
      last_sp = 0;
      r.drive = '0;
      r.loop_error = '0;
      r.drive_clamped = 1'b0;
      r.integ_clamped = 1'b0;
      return r;
    end
    if (op == OP_ANGLE) begin
      ff = scaled_mul(kff, wrap_angle(sp - last_sp));
      cur = wrap_angle(meas);
      spw = wrap_angle(sp);
      err = wrap_angle(spw - cur);
      last_sp = spw;
    end else begin
      err = clip32(sp - meas);
      if (op == OP_EXT_FF) ff = longint'($signed(f_raw));
      else if (op == OP_TGT_FF) ff = scaled_mul(kff, sp);
      else if (op == OP_VEL_FF) begin
        ff = scaled_mul(kff, clip32(sp - last_sp));
        last_sp = sp;
      end
    end
    p = scaled_mul(kp, err);
    d = scaled_mul(kd, -clip32(cur - last_meas));
    pre = p + scaled_mul(ki, accum) + d + ff;
    if (pre >= dhi && err > 0) hold = 1;
    else if (pre <= dlo && err < 0) hold = 1;
    if (!hold) accum = clip(accum + err, ACC_LO, ACC_HI);
    iout = scaled_mul(ki, accum);
    if (iout > ihi) begin
      iout = ihi;
      icl = 1;
      if (ki > 0) accum = (ihi * 65536) / ki;
    end else if (iout < ilo) begin
      iout = ilo;
      icl = 1;
      if (ki > 0) accum = (ilo * 65536) / ki;
    end
    total = p + iout + d + ff;
    if (total > dhi) begin
      total = dhi;
      dcl = 1;
    end else if (total < dlo) begin
      total = dlo;
      dcl = 1;
    end
    last_meas = cur;
    r.drive = total[31:0];
    r.loop_error = err[31:0];
    r.drive_clamped = dcl;
    r.integ_clamped = icl;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    gains_regs[idx] = longint'($signed(value));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_setting(logic [31:0] v [NUM_REGS]);
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[2:0], v[i]);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_step(step_row_t row);
    ctl_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.operation <= row.op;
    in_ch.measured <= row.meas;
    in_ch.setpoint <= row.sp;
    in_ch.ff_external <= row.ffx;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    r = control_step(row.op, row.meas, row.sp, row.ffx);
    pending_q.push_back(row.typed ? row.res : r);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic add_row(logic [2:0] op, logic [31:0] m, logic [31:0] s, logic [31:0] f);
    step_row_t row;
    row.op = op;
    row.meas = m;
    row.sp = s;
    row.ffx = f;
    row.typed = 0;
    rows.push_back(row);
  endtask

  task automatic add_typed(logic [2:0] op, logic [31:0] m, logic [31:0] s, logic [31:0] f,
                           logic [31:0] dr, logic [31:0] er, logic dc, logic ic);
    step_row_t row;
    row.op = op;
    row.meas = m;
    row.sp = s;
    row.ffx = f;
    row.typed = 1;
    row.res.drive = dr;
    row.res.loop_error = er;
    row.res.drive_clamped = dc;
    row.res.integ_clamped = ic;
    rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2, 3: return $urandom;
      4, 5: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
      6: return 32'($signed($urandom_range(2000 << 16)) - (1000 << 16));
      default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return $urandom;
      3: return 32'($urandom_range(3));
      default: return 32'($signed($urandom_range(6 << 16)) - (3 << 16));
    endcase
  endfunction

  task automatic random_setting();
    logic [31:0] v [NUM_REGS];
    logic [31:0] a, b;
    for (int i = 0; i < 4; i++) v[i] = pick_gain();
    for (int i = 4; i < NUM_REGS; i += 2) begin
      a = pick_value();
      b = pick_value();
      if ($urandom_range(5) != 0 && $signed(a) > $signed(b)) begin
        v[i] = b;
        v[i + 1] = a;
      end else begin
        v[i] = a;
        v[i + 1] = b;
      end
    end
    load_setting(v);
  endtask

  function automatic logic [2:0] pick_op();
    int k;
    k = $urandom_range(99);
    if (k < 20) return OP_EXT_FF;
    if (k < 40) return OP_TGT_FF;
    if (k < 60) return OP_VEL_FF;
    if (k < 85) return OP_ANGLE;
    if (k < 90) return OP_CLEAR;
    return 3'($urandom_range(5, 7));
  endfunction

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    ctl_result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction drive=%h", out_ch.drive);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.drive !== e.drive || out_ch.loop_error !== e.loop_error ||
            out_ch.drive_clamped !== e.drive_clamped ||
            out_ch.integ_clamped !== e.integ_clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected drive=%h err=%h dcl=%b icl=%b, got %h %h %b %b",
                     e.drive, e.loop_error, e.drive_clamped, e.integ_clamped,
                     out_ch.drive, out_ch.loop_error, out_ch.drive_clamped,
                     out_ch.integ_clamped);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("feedforward_pid_angle_wrap verification failed");
    $finish;
  end

  initial begin
    logic [31:0] mid [NUM_REGS];
    logic [31:0] edge_set [NUM_REGS];
    logic [31:0] swap_set [NUM_REGS];
    logic [31:0] m, s;
    step_row_t row;
    int blk_len;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_EXT_FF;
    in_ch.measured = '0;
    in_ch.setpoint = '0;
    in_ch.ff_external = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GAIN_P;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) gains_regs[i] = 0;
    accum = 0;
    last_meas = 0;
    last_sp = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero gains and limits after reset
    add_typed(OP_EXT_FF, S_MIN, S_MAX, 32'd5, '0, S_MAX, 1'b1, 1'b0);
    add_typed(OP_EXT_FF, S_MAX, S_MIN, '0, '0, S_MIN, 1'b0, 1'b0);
    add_typed(OP_CLEAR, S_MAX, S_MAX, S_MAX, '0, '0, 1'b0, 1'b0);
    foreach (rows[i]) send_step(rows[i]);
    rows.delete();

    mid = '{32'h0001_8000, 32'h0000_4000, 32'h0000_2000, 32'h0000_8000,
            -(32'd100 << 16), 32'd100 << 16, -(32'd20 << 16), 32'd20 << 16};
    load_setting(mid);
    add_row(OP_EXT_FF, 32'd10 << 16, 32'd12 << 16, 32'd1 << 16);
    add_row(OP_TGT_FF, 32'd3 << 16, 32'd50 << 16, '0);
    add_row(OP_VEL_FF, 32'd3 << 16, S_MAX, '0);
    add_row(OP_VEL_FF, S_MAX, S_MIN, '0);
    add_row(OP_ANGLE, -(32'd180 << 16), 32'd180 << 16, '0);
    add_row(OP_ANGLE, 32'd720 << 16, -(32'd540 << 16), '0);
    add_row(OP_ANGLE, S_MIN, S_MAX, '0);
    add_row(3'd5, S_MIN, S_MAX, S_MAX);
    add_row(3'd6, '0, 32'd5 << 16, '0);
    add_row(3'd7, 32'd1, '0, S_MIN);
    for (int i = 0; i < 4; i++) add_row(OP_EXT_FF, '0, 32'd90 << 16, '0);
    add_row(OP_CLEAR, '0, '0, '0);
    foreach (rows[i]) send_step(rows[i]);
    rows.delete();

    edge_set = '{S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX};
    load_setting(edge_set);
    add_row(OP_EXT_FF, S_MIN, S_MAX, S_MAX);
    add_row(OP_TGT_FF, S_MAX, S_MIN, S_MIN);
    add_row(OP_VEL_FF, S_MIN, S_MAX, '0);
    add_row(OP_ANGLE, S_MAX, S_MIN, '0);
    swap_set = '{S_MIN, 32'd1, 32'd1, S_MAX, 32'd50 << 16, -(32'd50 << 16),
                 32'd5 << 16, -(32'd5 << 16)};
    foreach (rows[i]) send_step(rows[i]);
    rows.delete();
    load_setting(swap_set);
    add_row(OP_EXT_FF, '0, 32'd7 << 16, '0);
    add_row(OP_ANGLE, 32'd10 << 16, -(32'd10 << 16), '0);
    add_row(OP_VEL_FF, '0, S_MIN, 32'hFFFF_FFFF);
    foreach (rows[i]) send_step(rows[i]);
    rows.delete();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 18 : 0;
      for (int b = 0; b < 8; b++) begin
        random_setting();
        blk_len = 67;
        m = pick_value();
        s = pick_value();
        for (int k = 0; k < blk_len; k++) begin
          // mostly smooth trajectories, sometimes a jump
          if ($urandom_range(9) == 0) begin
            m = pick_value();
            s = pick_value();
          end else begin
            m = m + 32'($signed($urandom_range(4 << 16)) - (2 << 16));
            s = s + 32'($signed($urandom_range(4 << 16)) - (2 << 16));
          end
          row.op = pick_op();
          row.meas = m;
          row.sp = s;
          row.ffx = pick_value();
          row.typed = 0;
          send_step(row);
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("covered %0d input transactions and %0d results over %0d register settings",
             n_items, n_results, n_settings);
    $display("all five operations plus unused codes, angle folding and clamp paths");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("feedforward_pid_angle_wrap verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("feedforward_pid_angle_wrap verification failed");
    end
    $finish;
  end
endmodule
